/* sv/lvrc_pkg.sv */
// Package for the leak valve relay controller: types, codes and step functions.
package lvrc_pkg;

	// Valve position codes
	localparam logic [2:0] VP_UNKNOWN = 3'd0;
	localparam logic [2:0] VP_OPENING = 3'd1;
	localparam logic [2:0] VP_OPENED  = 3'd2;
	localparam logic [2:0] VP_CLOSING = 3'd3;
	localparam logic [2:0] VP_CLOSED  = 3'd4;

	// Alarm mode codes
	localparam logic [1:0] AM_UNDECIDED = 2'd0;
	localparam logic [1:0] AM_ON        = 2'd1;
	localparam logic [1:0] AM_OFF       = 2'd2;

	// Control mode codes
	localparam logic [1:0] CM_CLOSE = 2'd1;
	localparam logic [1:0] CM_OPEN  = 2'd2;

	// Target mode bits
	localparam int TGT_CLOSE_BIT = 0;
	localparam int TGT_OPEN_BIT  = 1;

	// Configuration register indexes
	localparam logic [2:0] CFG_WORK     = 3'd0;
	localparam logic [2:0] CFG_GAP      = 3'd1;
	localparam logic [2:0] CFG_LEAK_THR = 3'd2;
	localparam logic [2:0] CFG_DRY_THR  = 3'd3;
	localparam logic [2:0] CFG_LEAK_CNT = 3'd4;
	localparam logic [2:0] CFG_CTRL_CNT = 3'd5;
	localparam logic [2:0] CFG_EXERCISE = 3'd6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 21;

	// Configuration reset values
	localparam logic [5:0]  WORK_RST     = 6'd30;
	localparam logic [3:0]  GAP_RST      = 4'd1;
	localparam logic [11:0] LEAK_THR_RST = 12'd2222;
	localparam logic [11:0] DRY_THR_RST  = 12'd2500;
	localparam logic [3:0]  LEAK_CNT_RST = 4'd4;
	localparam logic [3:0]  CTRL_CNT_RST = 4'd3;
	localparam logic [20:0] EXERCISE_RST = 21'd300;

	localparam logic [21:0] ROT_MAX = 22'h3FFFFF;
	localparam int SETTLE_PASSES = 4;

	typedef struct packed {
		logic [5:0]  work;
		logic [3:0]  gap;
		logic [11:0] leak_thr;
		logic [11:0] dry_thr;
		logic [3:0]  leak_cnt;
		logic [3:0]  ctrl_cnt;
		logic [20:0] exercise;
	} cfg_t;

	typedef struct packed {
		logic        action;
		logic [11:0] sensor_a;
		logic [11:0] sensor_b;
		logic        control_level;
	} item_t;

	typedef struct packed {
		logic       power_relay;
		logic       control_relay;
		logic       alarm_active;
		logic [2:0] position;
		logic       motor_open_state;
	} result_t;

	typedef struct packed {
		logic [2:0]        pos;
		logic [1:0]        am;
		logic [1:0]        tgt;
		logic [1:0]        cm;
		logic              motion;
		logic              power_on;
		logic              dir_on;
		logic [5:0]        pt;
		logic [6:0]        dt;
		logic [3:0]        gt;
		logic [21:0]       rot;
		logic signed [5:0] lc;
		logic signed [5:0] cc;
	} st_t;

	function automatic logic in_motion(st_t s);
		return (s.pos == VP_OPENING) || (s.pos == VP_CLOSING);
	endfunction

	function automatic st_t begin_close(st_t s, cfg_t c);
		if (s.pos != VP_CLOSING && s.pos != VP_CLOSED && s.motion) begin
			s.pos      = VP_CLOSING;
			s.power_on = 1'b0;
			s.dir_on   = 1'b1;
			s.dt       = {2'b00, c.gap, 1'b0} + {1'b0, c.work};
			s.pt       = c.work;
			s.gt       = c.gap;
			s.rot      = '0;
		end
		return s;
	endfunction

	function automatic st_t begin_open(st_t s, cfg_t c);
		if (s.pos != VP_OPENED && s.pos != VP_OPENING && s.motion) begin
			s.pos      = VP_OPENING;
			s.dir_on   = 1'b0;
			s.power_on = 1'b1;
			s.pt       = c.work;
		end
		return s;
	endfunction

	function automatic st_t want_close(st_t s, cfg_t c);
		if (s.pos == VP_UNKNOWN) s.pos = VP_OPENED;
		if (s.pos == VP_OPENED && s.tgt[TGT_CLOSE_BIT] && !in_motion(s))
			s = begin_close(s, c);
		return s;
	endfunction

	function automatic st_t want_open(st_t s, cfg_t c);
		if (s.pos == VP_UNKNOWN) s.pos = VP_CLOSED;
		if (s.pos == VP_CLOSED && s.tgt[TGT_OPEN_BIT])
			s = begin_open(s, c);
		return s;
	endfunction

	function automatic st_t follow_request(st_t s, cfg_t c);
		if (s.tgt[TGT_OPEN_BIT] && s.cm == CM_OPEN && s.am == AM_OFF && s.motion &&
				!in_motion(s) && (s.pos == VP_CLOSED || s.pos == VP_UNKNOWN))
			s = want_open(s, c);
		if (s.tgt[TGT_CLOSE_BIT] && s.cm == CM_CLOSE && s.motion &&
				(s.pos == VP_OPENED || s.pos == VP_UNKNOWN) && !in_motion(s))
			s = want_close(s, c);
		return s;
	endfunction

	function automatic st_t exercise_check(st_t s, cfg_t c);
		if (s.rot > {1'b0, c.exercise} && s.pos == VP_CLOSED && s.am == AM_OFF &&
				s.tgt[TGT_OPEN_BIT]) begin
			s = want_open(s, c);
			s.rot = '0;
			s.tgt[TGT_CLOSE_BIT] = 1'b0;
		end
		if (s.rot > {1'b0, c.exercise} && s.pos == VP_OPENED) begin
			s.tgt[TGT_CLOSE_BIT] = 1'b1;
			s = want_close(s, c);
		end
		return s;
	endfunction

	function automatic st_t sample_control(st_t s, cfg_t c, logic level);
		logic signed [5:0] lim;
		lim = $signed({2'b00, c.ctrl_cnt});
		if (level) s.cc = s.cc - 6'sd1;
		else s.cc = s.cc + 6'sd1;
		if (s.cc > lim) begin
			s.cc  = lim;
			s.cm  = CM_CLOSE;
			s.tgt = 2'b01;
		end else if (s.cc < -lim) begin
			s.cc  = -lim;
			s.cm  = CM_OPEN;
			s.tgt = 2'b10;
		end
		return s;
	endfunction

	function automatic st_t sample_leak(st_t s, cfg_t c, logic [11:0] a, logic [11:0] b);
		logic signed [5:0] lim;
		logic [11:0]       lvl;
		lim = $signed({2'b00, c.leak_cnt});
		lvl = (a < b) ? a : b;
		if (lvl < c.leak_thr) s.lc = s.lc + 6'sd1;
		else if (lvl > c.dry_thr) s.lc = s.lc - 6'sd1;
		if (s.lc > lim) begin
			s.tgt = 2'b01;
			s.am  = AM_ON;
			s.lc  = lim;
		end
		if (s.lc < -lim) begin
			s.am = AM_OFF;
			s.lc = -lim;
		end
		return s;
	endfunction

	function automatic st_t second_tick(st_t s);
		s.motion = 1'b1;
		if (s.pos != VP_CLOSED && s.rot != ROT_MAX) s.rot = s.rot + 22'd1;
		if (s.pos == VP_OPENING) begin
			if (s.pt != '0) s.pt = s.pt - 6'd1;
			if (s.pt == '0) begin
				s.power_on = 1'b0;
				s.pos      = VP_OPENED;
			end
		end else if (s.pos == VP_CLOSING) begin
			if (s.gt == '0) begin
				if (s.pt != '0) begin
					s.power_on = 1'b1;
					s.pt       = s.pt - 6'd1;
				end else begin
					s.power_on = 1'b0;
				end
			end else begin
				s.gt = s.gt - 4'd1;
			end
			if (s.dt != '0) s.dt = s.dt - 7'd1;
			if (s.dt == '0) begin
				s.dir_on   = 1'b0;
				s.power_on = 1'b0;
				s.pos      = VP_CLOSED;
			end
		end
		return s;
	endfunction

	function automatic st_t settle_pass(st_t s, cfg_t c);
		if (s.am == AM_ON) begin
			s = want_close(s, c);
		end else begin
			s = follow_request(s, c);
			s = exercise_check(s, c);
		end
		return s;
	endfunction

endpackage

/* sv/lvrc_if.sv */
// Valid/ready channel interfaces for items and results of the valve controller.
interface lvrc_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [11:0] sensor_a;
	logic [11:0] sensor_b;
	logic        control_level;

	modport source(output valid, output action, output sensor_a, output sensor_b,
		output control_level, input ready);
	modport sink(input valid, input action, input sensor_a, input sensor_b,
		input control_level, output ready);
endinterface

interface lvrc_result_if;
	logic       valid;
	logic       ready;
	logic       power_relay;
	logic       control_relay;
	logic       alarm_active;
	logic [2:0] position;
	logic       motor_open_state;

	modport source(output valid, output power_relay, output control_relay,
		output alarm_active, output position, output motor_open_state, input ready);
	modport sink(input valid, input power_relay, input control_relay,
		input alarm_active, input position, input motor_open_state, output ready);
endinterface

/* sv/leak_valve_relay_controller.sv */
// Top level of the leak valve relay controller: config registers and handshake stages.
// Path: an accepted item is held in the input register, and its result is registered in the output register.
// Throughput: one item per cycle while results are taken; the state update is one combinational pass per item.
// While a finished result waits, the input register takes one more item, then input stalls.
// Reset: arst_n clears state, valid flags and loads the configuration defaults.
module leak_valve_relay_controller (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lvrc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lvrc_pkg::CFG_DATA_W-1:0]  cfg_data,
	lvrc_item_if.sink                         items,
	lvrc_result_if.source                     results
);
	import lvrc_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t core_result;
	logic    advance;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.work     <= WORK_RST;
			cfg_q.gap      <= GAP_RST;
			cfg_q.leak_thr <= LEAK_THR_RST;
			cfg_q.dry_thr  <= DRY_THR_RST;
			cfg_q.leak_cnt <= LEAK_CNT_RST;
			cfg_q.ctrl_cnt <= CTRL_CNT_RST;
			cfg_q.exercise <= EXERCISE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WORK:     cfg_q.work     <= cfg_data[5:0];
				CFG_GAP:      cfg_q.gap      <= cfg_data[3:0];
				CFG_LEAK_THR: cfg_q.leak_thr <= cfg_data[11:0];
				CFG_DRY_THR:  cfg_q.dry_thr  <= cfg_data[11:0];
				CFG_LEAK_CNT: cfg_q.leak_cnt <= cfg_data[3:0];
				CFG_CTRL_CNT: cfg_q.ctrl_cnt <= cfg_data[3:0];
				CFG_EXERCISE: cfg_q.exercise <= cfg_data[20:0];
				default: ;
			endcase
		end
	end

	// Move the staged item into the output register when it is free
	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	// Hold the accepted transaction in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.action        <= items.action;
			item_s1.sensor_a      <= items.sensor_a;
			item_s1.sensor_b      <= items.sensor_b;
			item_s1.control_level <= items.control_level;
		end
	end

	lvrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step_en(advance),
		.item   (item_s1),
		.result (core_result)
	);

	// Register the result and drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) out_q <= core_result;
	end

	assign results.valid            = out_valid_q;
	assign results.power_relay      = out_q.power_relay;
	assign results.control_relay    = out_q.control_relay;
	assign results.alarm_active     = out_q.alarm_active;
	assign results.position         = out_q.position;
	assign results.motor_open_state = out_q.motor_open_state;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> items.ready)
		else $error("input stalled with an empty output register");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("staged item lost while stalled");

	a_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("stepped item produced no result");

endmodule

/* sv/lvrc_core.sv */
// Valve controller state register and combinational step logic.
module lvrc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  lvrc_pkg::cfg_t   cfg,
	input  logic             step_en,
	input  lvrc_pkg::item_t  item,
	output lvrc_pkg::result_t result
);
	import lvrc_pkg::*;

	st_t st_q;
	st_t st_nxt;

	// Apply one item, then settle the idle decisions
	always_comb begin
		st_nxt = st_q;
		if (!item.action) begin
			st_nxt = second_tick(st_nxt);
		end else if (st_nxt.am != AM_ON) begin
			st_nxt = sample_control(st_nxt, cfg, item.control_level);
			st_nxt = follow_request(st_nxt, cfg);
			st_nxt = sample_leak(st_nxt, cfg, item.sensor_a, item.sensor_b);
			st_nxt = exercise_check(st_nxt, cfg);
		end
		for (int p = 0; p < SETTLE_PASSES; p++) begin
			st_nxt = settle_pass(st_nxt, cfg);
		end
	end

	// Derive the result fields from the updated state
	always_comb begin
		result.power_relay      = st_nxt.power_on;
		result.control_relay    = st_nxt.dir_on;
		result.alarm_active     = (st_nxt.am == AM_ON);
		result.position         = st_nxt.pos;
		result.motor_open_state = (st_nxt.pos == VP_OPENING) || (st_nxt.pos == VP_OPENED);
	end

	// Advance state on each stepped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step_en) begin
			st_q <= st_nxt;
		end
	end

	a_alarm_latched: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.am == AM_ON) |=> (st_q.am == AM_ON))
		else $error("leak alarm cleared after latching");

	a_power_in_move: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.power_on |-> (st_q.pos == VP_OPENING || st_q.pos == VP_CLOSING))
		else $error("power relay on outside a move");

	a_dir_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.dir_on |-> (st_q.pos == VP_CLOSING))
		else $error("control relay on while not closing");

endmodule
